// ----- sv/lcvb_pkg.sv -----
// Shared types and codes for the LED cube voxel buffer.
// Holds command, axis and direction codes and the row cell control struct.
// No dependencies.
package lcvb_pkg;

  localparam int unsigned CubeN    = 8;

  // Command codes carried in the op field
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_SETVOX = 3'd1;
  localparam logic [2:0] OP_PLANE  = 3'd2;
  localparam logic [2:0] OP_SHIFT  = 3'd3;
  localparam logic [2:0] OP_RENDER = 3'd4;

  // Plane axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Shift direction codes
  localparam logic [2:0] DIR_XP = 3'd0;
  localparam logic [2:0] DIR_XM = 3'd1;
  localparam logic [2:0] DIR_ZP = 3'd2;
  localparam logic [2:0] DIR_ZM = 3'd3;
  localparam logic [2:0] DIR_YP = 3'd4;
  localparam logic [2:0] DIR_YM = 3'd5;

  // Per-cycle action of one row cell
  typedef enum logic [3:0] {
    ACT_HOLD     = 4'd0,
    ACT_CLEAR    = 4'd1,
    ACT_SET_VOX  = 4'd2,
    ACT_PLANE_X  = 4'd3,
    ACT_ROW_ONES = 4'd4,
    ACT_PLANE_Z  = 4'd5,
    ACT_SHIFT_XP = 4'd6,
    ACT_SHIFT_XM = 4'd7,
    ACT_SHIFT_ZP = 4'd8,
    ACT_SHIFT_ZM = 4'd9,
    ACT_FROM_UP  = 4'd10,
    ACT_FROM_DN  = 4'd11
  } cell_act_t;

  typedef struct packed {
    cell_act_t  act;
    logic [2:0] bit_idx;   // x bit within a byte
    logic [2:0] byte_idx;  // byte within the row
  } cell_ctrl_t;

endpackage

// ----- sv/led_cube_voxel_buffer.sv -----
// LED cube voxel buffer: 8x8x8 voxel store as a chain of eight row cells.
// Clear, set voxel, set plane and shift update the store at the accepting edge
// and the next item can be taken in the next cycle. A render holds in_tready low
// until all eight layer words are registered; the chain rotates one row per cycle
// but stalls while a registered word waits on out_tready. Each step registers row 7
// as the next layer word. Sync active-low reset clears store, valid.
module led_cube_voxel_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] op, [5:3] x_coord, [8:6] y_coord, [11:9] z_coord,
  // [13:12] axis_sel, [16:14] plane_pos, [19:17] shift_dir, [23:20] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [63:0] row_data
  output logic [63:0] out_tdata,
  // [7:0] layer_select
  output logic [7:0]  out_tuser,
  output logic        out_tlast
);
  import lcvb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RENDER = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [7:0]  out_sel_r, out_sel_nxt;
  logic        out_last_r, out_last_nxt;

  logic [2:0] op, x_coord, y_coord, z_coord, plane_pos, shift_dir;
  logic [1:0] axis_sel;
  logic       in_acc, advance;

  cell_ctrl_t  ctrl  [CubeN];
  logic [63:0] rows  [CubeN];
  logic [63:0] up_in [CubeN];
  logic [63:0] dn_in [CubeN];
  logic [63:0] send_row;

  assign op        = in_tdata[2:0];
  assign x_coord   = in_tdata[5:3];
  assign y_coord   = in_tdata[8:6];
  assign z_coord   = in_tdata[11:9];
  assign axis_sel  = in_tdata[13:12];
  assign plane_pos = in_tdata[16:14];
  assign shift_dir = in_tdata[19:17];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign advance   = (state_r == ST_RENDER) && (!out_valid_r || out_tready);

  // Decode one control word per row cell
  for (genvar r = 0; r < CubeN; r++) begin : g_cell
    logic row_y_hit, row_p_hit;
    assign row_y_hit = (3'(r) == ~y_coord);
    assign row_p_hit = (3'(r) == ~plane_pos);

    always_comb begin
      ctrl[r].act      = ACT_HOLD;
      ctrl[r].bit_idx  = x_coord;
      ctrl[r].byte_idx = ~z_coord;
      if (advance) begin
        ctrl[r].act = ACT_FROM_DN;
      end else if (in_acc) begin
        unique case (op)
          OP_CLEAR:  ctrl[r].act = ACT_CLEAR;
          OP_SETVOX: ctrl[r].act = row_y_hit ? ACT_SET_VOX : ACT_HOLD;
          OP_PLANE: begin
            ctrl[r].bit_idx  = plane_pos;
            ctrl[r].byte_idx = ~plane_pos;
            unique case (axis_sel)
              AXIS_X:  ctrl[r].act = ACT_PLANE_X;
              AXIS_Y:  ctrl[r].act = row_p_hit ? ACT_ROW_ONES : ACT_HOLD;
              AXIS_Z:  ctrl[r].act = ACT_PLANE_Z;
              default: ctrl[r].act = ACT_HOLD;
            endcase
          end
          OP_SHIFT: begin
            unique case (shift_dir)
              DIR_XP:  ctrl[r].act = ACT_SHIFT_XP;
              DIR_XM:  ctrl[r].act = ACT_SHIFT_XM;
              DIR_ZP:  ctrl[r].act = ACT_SHIFT_ZP;
              DIR_ZM:  ctrl[r].act = ACT_SHIFT_ZM;
              DIR_YP:  ctrl[r].act = ACT_FROM_UP;
              DIR_YM:  ctrl[r].act = ACT_FROM_DN;
              default: ctrl[r].act = ACT_HOLD;
            endcase
          end
          default: ctrl[r].act = ACT_HOLD;
        endcase
      end
    end

    // Neighbor links: top end takes zeros, bottom end wraps row 7 on render
    if (r == CubeN - 1) begin : g_top
      assign up_in[r] = '0;
    end else begin : g_mid_up
      assign up_in[r] = rows[r+1];
    end
    if (r == 0) begin : g_bot
      assign dn_in[r] = advance ? rows[CubeN-1] : '0;
    end else begin : g_mid_dn
      assign dn_in[r] = rows[r-1];
    end

    lcvb_row_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl[r]),
      .up_row (up_in[r]),
      .dn_row (dn_in[r]),
      .row_q  (rows[r])
    );
  end

  // Swap bytes in pairs for send order 1,0,3,2,5,4,7,6
  always_comb begin
    for (int n = 0; n < CubeN; n++) begin
      send_row[8*n +: 8] = rows[CubeN-1][8*(n ^ 1) +: 8];
    end
  end

  // Render sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sel_nxt   = out_sel_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (op == OP_RENDER)) begin
          state_nxt = ST_RENDER;
          cnt_nxt   = '0;
        end
      end
      ST_RENDER: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = send_row;
          out_sel_nxt   = 8'b1 << cnt_r;
          out_last_nxt  = (cnt_r == 3'(CubeN - 1));
          cnt_nxt       = cnt_r + 3'd1;
          if (cnt_r == 3'(CubeN - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Hold control state; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_sel_r  <= out_sel_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sel_r;
  assign out_tlast  = out_last_r;

  // A render command always starts the sequencer
  a_render_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_RENDER) |=> state_r == ST_RENDER)
    else $error("render command did not start the sequencer");

  // Layer counter rests at zero between renders
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r == 3'd0)
    else $error("layer counter not at zero while idle");

  // Layer select is one-hot whenever a word is offered
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_sel_r))
    else $error("layer select not one-hot");

  // The last word of a frame is the top layer select
  a_last_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_sel_r == 8'h80)
    else $error("frame end on wrong layer");

endmodule

// ----- sv/lcvb_row_cell.sv -----
// One row of the voxel store: eight bytes of eight x-bits.
// Applies the action chosen by the top level or takes a neighbor's row.
// Depends on lcvb_pkg.
module lcvb_row_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lcvb_pkg::cell_ctrl_t ctrl,
  input  logic [63:0]         up_row,   // row r+1, or zeros at the top end
  input  logic [63:0]         dn_row,   // row r-1, or wrap / zeros at the bottom end
  output logic [63:0]         row_q
);
  import lcvb_pkg::*;

  logic [63:0] row_r, row_nxt;
  logic [7:0]  bit_mask;
  logic [5:0]  byte_lsb;

  assign bit_mask = 8'b1 << ctrl.bit_idx;
  assign byte_lsb = {ctrl.byte_idx, 3'b000};

  // Compute the next row contents
  always_comb begin
    row_nxt = row_r;
    unique case (ctrl.act)
      ACT_HOLD:     row_nxt = row_r;
      ACT_CLEAR:    row_nxt = '0;
      ACT_SET_VOX:  row_nxt[byte_lsb +: 8] = row_r[byte_lsb +: 8] | bit_mask;
      ACT_PLANE_X:  row_nxt = row_r | {8{bit_mask}};
      ACT_ROW_ONES: row_nxt = '1;
      ACT_PLANE_Z:  row_nxt[byte_lsb +: 8] = 8'hFF;
      ACT_SHIFT_XP: row_nxt = (row_r << 1) & {8{8'hFE}};
      ACT_SHIFT_XM: row_nxt = (row_r >> 1) & {8{8'h7F}};
      ACT_SHIFT_ZP: row_nxt = row_r >> 8;
      ACT_SHIFT_ZM: row_nxt = row_r << 8;
      ACT_FROM_UP:  row_nxt = up_row;
      ACT_FROM_DN:  row_nxt = dn_row;
      default:      row_nxt = row_r;
    endcase
  end

  // Store the row; reset turns all voxels off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule
